[hdl/tre_pkg.sv]
// ----------------------------------------------------------------------------
// tre_pkg
// Shared beat types and command codes for the run-length pixel encoder.
// ----------------------------------------------------------------------------
package tre_pkg;

    localparam int PIX_W = 24;
    localparam int HDR_W = 8;
    localparam int CNT_W = 3;

    // Command codes carried by an input beat
    localparam logic [1:0] CMD_PIXEL  = 2'd0;
    localparam logic [1:0] CMD_RESET  = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [HDR_W-1:0] HDR_NONE = 8'h00;
    localparam logic             RUN_FLAG = 1'b1;
    localparam logic             RAW_FLAG = 1'b0;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [PIX_W-1:0] pixel_value;
    } in_beat_t;

    typedef struct packed {
        logic             has_header;
        logic [HDR_W-1:0] header_byte;
        logic [CNT_W-1:0] pixel_count;
        logic [PIX_W-1:0] pixel_a;
        logic [PIX_W-1:0] pixel_b;
        logic [PIX_W-1:0] pixel_c;
        logic [PIX_W-1:0] pixel_d;
        logic             last_word;
    } out_beat_t;

    // One-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_PUSH = 4'b0100,
        S_RUN  = 4'b1000
    } tre_state_t;

endpackage

[hdl/tre_ram.sv]
// ----------------------------------------------------------------------------
// tre_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tre_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/tre_out_stage.sv]
// ----------------------------------------------------------------------------
// tre_out_stage
// Output holding register; frees itself when the downstream takes the beat.
// ----------------------------------------------------------------------------
module tre_out_stage
    import tre_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_beat_t word,
    output logic      free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      valid_reg;
    out_beat_t data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= word;
        end
    end

endmodule

[hdl/tga_rle_pixel_encoder_core.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder_core
// 24-bit run-length pixel encoder producing header/pixel packet beats.
// ----------------------------------------------------------------------------
// Pixels and commands arrive one beat at a time; in RLE mode the block keeps
// the current run (pixel and count) in registers and parks lone pixels in a
// LITERAL_DEPTH-entry literal RAM. A pixel that extends a run or sends the
// prior lone pixel to the RAM is taken in the idle state; the next beat is
// taken right after. A pixel that breaks a longer run (or finds the literal
// RAM full), and a flush, emit the pending packets: each raw word of up to
// four pixels reads them one at a time over the single read port of the
// literal RAM and is then pushed; the run word follows. No input is taken
// while packets are being emitted. Raw mode sends each pixel as a one-pixel
// word. Output beats sit in a holding register, so the input side keeps going
// while a beat waits for out_ready, until another beat has to be loaded.
// Reset, unused commands and a flush in raw mode emit nothing; cfg_data
// (output mode) is always accepted and must only change while idle.
// ----------------------------------------------------------------------------
module tga_rle_pixel_encoder_core
    import tre_pkg::*;
#(
    parameter int MAX_RUN       = 128,
    parameter int LITERAL_DEPTH = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    // configuration: output_mode
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    // input beats
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    // output beats
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    // fill counter holds 0..LITERAL_DEPTH, run counter 0..MAX_RUN
    localparam int FW = $clog2(LITERAL_DEPTH + 1);
    localparam int AW = $clog2(LITERAL_DEPTH);
    localparam int RW = $clog2(MAX_RUN + 1);
    localparam int CW = FW + 3;

    tre_state_t       state_reg, state_next;
    logic             mode_reg;
    logic [PIX_W-1:0] held_reg, held_next;
    logic [RW-1:0]    run_reg, run_next;
    logic [FW-1:0]    fill_reg, fill_next;

    // emission bookkeeping
    logic [FW-1:0]    emit_fill_reg, emit_fill_next;
    logic             run_pend_reg, run_pend_next;
    out_beat_t        pend_word_reg, pend_word_next;
    logic [FW-1:0]    word_pos_reg, word_pos_next;
    logic [2:0]       slot_issue_reg, slot_issue_next;
    logic             cap_valid_reg, cap_valid_next;
    logic [1:0]       cap_slot_reg, cap_slot_next;
    logic [PIX_W-1:0] pix_slot_reg [4];

    // literal RAM port signals
    logic             ram_we;
    logic [AW-1:0]    ram_wa;
    logic             ram_re;
    logic [AW-1:0]    ram_ra;
    logic [PIX_W-1:0] ram_rdata;

    // output stage
    logic             out_load;
    out_beat_t        out_word;
    logic             out_free;

    // word shaping
    logic [FW-1:0]    remain;
    logic [2:0]       word_n;
    logic             more_words;
    logic [FW-1:0]    fill_m1;
    logic [RW-1:0]    run_m1;
    out_beat_t        lit_word;
    out_beat_t        run_word;
    out_beat_t        raw_word;
    logic             do_emit;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    // pixels left in the literal packet from the current word on
    assign remain     = emit_fill_reg - word_pos_reg;
    assign word_n     = (CW'(remain) > CW'(4)) ? 3'd4 : 3'(remain);
    assign more_words = CW'(remain) > CW'(word_n);
    assign ram_ra     = AW'(word_pos_reg + FW'(slot_issue_reg));

    assign fill_m1 = emit_fill_reg - FW'(1);
    assign run_m1  = run_reg - RW'(1);

    always_comb
    begin
        lit_word.has_header  = (word_pos_reg == '0);
        lit_word.header_byte = (word_pos_reg == '0) ? {RAW_FLAG, 7'(fill_m1)} : HDR_NONE;
        lit_word.pixel_count = word_n;
        lit_word.pixel_a     = (word_n > 3'd0) ? pix_slot_reg[0] : '0;
        lit_word.pixel_b     = (word_n > 3'd1) ? pix_slot_reg[1] : '0;
        lit_word.pixel_c     = (word_n > 3'd2) ? pix_slot_reg[2] : '0;
        lit_word.pixel_d     = (word_n > 3'd3) ? pix_slot_reg[3] : '0;
        lit_word.last_word   = !more_words && !run_pend_reg;

        // run packet built from the run being closed
        run_word.has_header  = 1'b1;
        run_word.header_byte = {RUN_FLAG, 7'(run_m1)};
        run_word.pixel_count = 3'd1;
        run_word.pixel_a     = held_reg;
        run_word.pixel_b     = '0;
        run_word.pixel_c     = '0;
        run_word.pixel_d     = '0;
        run_word.last_word   = 1'b1;

        raw_word.has_header  = 1'b0;
        raw_word.header_byte = HDR_NONE;
        raw_word.pixel_count = 3'd1;
        raw_word.pixel_a     = in_data.pixel_value;
        raw_word.pixel_b     = '0;
        raw_word.pixel_c     = '0;
        raw_word.pixel_d     = '0;
        raw_word.last_word   = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        run_next        = run_reg;
        fill_next       = fill_reg;
        emit_fill_next  = emit_fill_reg;
        run_pend_next   = run_pend_reg;
        pend_word_next  = pend_word_reg;
        word_pos_next   = word_pos_reg;
        slot_issue_next = slot_issue_reg;
        cap_valid_next  = 1'b0;
        cap_slot_next   = cap_slot_reg;
        ram_we          = 1'b0;
        ram_wa          = AW'(fill_reg);
        ram_re          = 1'b0;
        out_load        = 1'b0;
        out_word        = lit_word;
        do_emit         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.cmd)
                        CMD_RESET:
                        begin
                            held_next = '0;
                            run_next  = '0;
                            fill_next = '0;
                        end
                        CMD_FLUSH:
                        begin
                            if (!mode_reg)
                            begin
                                do_emit  = 1'b1;
                                run_next = '0;
                            end
                        end
                        CMD_PIXEL:
                        begin
                            if (mode_reg)
                            begin
                                pend_word_next = raw_word;
                                state_next     = S_RUN;
                            end
                            else if (run_reg != '0 && held_reg == in_data.pixel_value
                                     && run_reg < RW'(MAX_RUN))
                            begin
                                run_next = run_reg + RW'(1);
                            end
                            else
                            begin
                                held_next = in_data.pixel_value;
                                run_next  = RW'(1);
                                if (run_reg == RW'(1) && fill_reg < FW'(LITERAL_DEPTH))
                                begin
                                    // lone pixel: park it
                                    ram_we    = 1'b1;
                                    fill_next = fill_reg + FW'(1);
                                end
                                else if (run_reg != '0)
                                begin
                                    do_emit = 1'b1;
                                end
                            end
                        end
                        CMD_UNUSED:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_emit)
                    begin
                        emit_fill_next  = fill_reg;
                        run_pend_next   = (run_reg != '0);
                        pend_word_next  = run_word;
                        fill_next       = '0;
                        word_pos_next   = '0;
                        slot_issue_next = '0;
                        if (fill_reg != '0)
                        begin
                            state_next = S_READ;
                        end
                        else if (run_reg != '0)
                        begin
                            state_next = S_RUN;
                        end
                    end
                end
            end
            S_READ:
            begin
                // one literal read per cycle; RAM read data is registered
                if (slot_issue_reg < word_n)
                begin
                    ram_re          = 1'b1;
                    cap_valid_next  = 1'b1;
                    cap_slot_next   = slot_issue_reg[1:0];
                    slot_issue_next = slot_issue_reg + 3'd1;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_word        = lit_word;
                    word_pos_next   = word_pos_reg + FW'(word_n);
                    slot_issue_next = '0;
                    if (more_words)
                    begin
                        state_next = S_READ;
                    end
                    else if (run_pend_reg)
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RUN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_word   = pend_word_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= 1'b0;
            held_reg       <= '0;
            run_reg        <= '0;
            fill_reg       <= '0;
            emit_fill_reg  <= '0;
            run_pend_reg   <= 1'b0;
            word_pos_reg   <= '0;
            slot_issue_reg <= '0;
            cap_valid_reg  <= 1'b0;
            cap_slot_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            run_reg        <= run_next;
            fill_reg       <= fill_next;
            emit_fill_reg  <= emit_fill_next;
            run_pend_reg   <= run_pend_next;
            word_pos_reg   <= word_pos_next;
            slot_issue_reg <= slot_issue_next;
            cap_valid_reg  <= cap_valid_next;
            cap_slot_reg   <= cap_slot_next;
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_word_reg <= pend_word_next;
        if (cap_valid_reg)
        begin
            pix_slot_reg[cap_slot_reg] <= ram_rdata;
        end
    end

    tre_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LITERAL_DEPTH)
    ) u_literal_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (held_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rdata)
    );

    tre_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .word      (out_word),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[hdl/tre_checker.sv]
// ----------------------------------------------------------------------------
// tre_checker
// Port-level checks on the encoder's output beats, bound to the top level.
// ----------------------------------------------------------------------------
module tre_checker
    import tre_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // every beat carries one to four pixels
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.pixel_count != 3'd0 && out_data.pixel_count <= 3'd4)
        else $error("pixel count out of range");

    // a beat without header has a zero header byte
    a_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.has_header |-> out_data.header_byte == HDR_NONE)
        else $error("header byte set without header");

    // run packets are a single one-pixel closing beat
    a_run_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.has_header && out_data.header_byte[7]
        |-> out_data.pixel_count == 3'd1 && out_data.last_word)
        else $error("malformed run packet");

    // an unused fourth slot stays clear
    a_slot_d: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.pixel_count != 3'd4 |-> out_data.pixel_d == '0)
        else $error("unused pixel slot not cleared");

endmodule

bind tga_rle_pixel_encoder_core tre_checker u_tre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
